>>> sv/ost_pkg.sv
// ordered set table package: transfer payload structs, operation and status codes,
// and the control bundle that the top level broadcasts to every cell
// no dependencies
package ost_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_MARK   = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam int COUNT_BITS = 7;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        count_t     count;
    } rsp_item_t;

    // broadcast to all cells
    typedef struct packed {
        logic       cmp;        // capture key compare into match flag
        logic       act;        // apply the operation this cycle
        logic [1:0] op;
        logic       any_match;  // some cell holds the key
    } cell_ctrl_t;

endpackage

>>> sv/ost_cell.sv
// one slot of the ordered set table: entry value, occupancy, keep mark, match flag
// depends on ost_pkg; instantiated in a row by ordered_set_table
module ost_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ost_pkg::cell_ctrl_t    ctrl,
    input  logic [VALUE_BITS-1:0]  key,
    input  logic                   left_valid,
    input  logic                   right_valid,
    input  logic [VALUE_BITS-1:0]  right_value,
    input  logic                   right_mark,
    output logic [VALUE_BITS-1:0]  value,
    output logic                   valid,
    output logic                   mark,
    output logic                   match
);
    import ost_pkg::*;

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  valid_reg, valid_next;
    logic                  mark_reg, mark_next;
    logic                  match_reg, match_next;

    // operation or one compaction step toward the head of the row
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        mark_next  = mark_reg;
        match_next = match_reg;
        if (ctrl.cmp)
        begin
            match_next = valid_reg && (value_reg == key);
        end
        if (ctrl.act)
        begin
            unique case (ctrl.op)
                OP_INSERT:
                begin
                    // first free slot takes a new key
                    if (!ctrl.any_match && !valid_reg && left_valid)
                    begin
                        value_next = key;
                        valid_next = 1'b1;
                        mark_next  = 1'b0;
                    end
                end
                OP_REMOVE:
                begin
                    if (match_reg)
                    begin
                        valid_next = 1'b0;
                        mark_next  = 1'b0;
                    end
                end
                OP_MARK:
                begin
                    if (match_reg)
                    begin
                        mark_next = 1'b1;
                    end
                end
                OP_FINISH:
                begin
                    if (!mark_reg)
                    begin
                        valid_next = 1'b0;
                    end
                    mark_next = 1'b0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
        else if (!valid_reg)
        begin
            // empty slot pulls its right neighbor
            value_next = right_value;
            valid_next = right_valid;
            mark_next  = right_mark;
        end
        else if (!left_valid)
        begin
            // content moved into the empty left neighbor
            valid_next = 1'b0;
            mark_next  = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
            match_reg <= match_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign mark  = mark_reg;
    assign match = match_reg;

endmodule

>>> sv/ordered_set_table.sv
// ordered set table top level: sequencer, response register and the row of cells
// depends on ost_pkg and ost_cell
//
// Usage: a request transfer on req (req_valid/req_ready, payload req_data) carries
// an operation and a value; exactly one response transfer follows on rsp
// (rsp_valid/rsp_ready, payload rsp_data) with a status and the element count.
// Values are held in a row of CAPACITY cells in insertion order, slot 0 first.
// Insert and keep-mark run a compare step in every cell, then an apply step that
// applies the operation and loads the response register. The next request
// is taken the cycle after the apply step.
// Remove answers at the same apply step but then closes the gap; keep-finish drops
// every unmarked entry and answers once the row is packed. The gap closes by one
// slot per cycle through the neighbor links, and the next request is taken only
// when the row is packed again.
// Reset empties the table and clears all marks; entry values are not cleared.
// The response register parts the two sides: a new request is accepted while a
// response still waits, and the sequencer only holds in its apply or finish step
// when the previous response has not yet been taken by the receiver.
module ordered_set_table #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ost_pkg::req_item_t  req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ost_pkg::rsp_item_t  rsp_data
);
    import ost_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ACT,
        S_PACK
    } state_t;

    state_t                state_reg;
    logic [1:0]            op_reg;
    logic [VALUE_BITS-1:0] key_reg;
    logic [CW-1:0]         count_reg;
    logic                  rsp_valid_reg;
    rsp_item_t             rsp_data_reg;

    cell_ctrl_t            ctrl;
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]   valid_vec;
    logic [CAPACITY-1:0]   mark_vec;
    logic [CAPACITY-1:0]   match_vec;
    logic [CAPACITY-1:0]   left_valid;
    logic [CAPACITY-1:0]   right_valid;
    logic [CAPACITY-1:0]   right_mark;
    logic                  settled;
    logic                  full;
    logic                  rsp_free;
    logic                  rsp_load;
    logic [CW-1:0]         count_enc;

    // neighbor views of the occupancy and marks
    assign left_valid  = {valid_vec[CAPACITY-2:0], 1'b1};
    assign right_valid = {1'b0, valid_vec[CAPACITY-1:1]};
    assign right_mark  = {1'b0, mark_vec[CAPACITY-1:1]};
    assign settled     = ~|(~valid_vec & right_valid);
    assign full        = valid_vec[CAPACITY-1];
    assign rsp_free    = !rsp_valid_reg || rsp_ready;

    // response loads at the apply step, or once a keep-finish has packed the row
    assign rsp_load = rsp_free &&
                      (((state_reg == S_ACT) && (op_reg != OP_FINISH)) ||
                       ((state_reg == S_PACK) && settled && (op_reg == OP_FINISH)));

    // broadcast control
    always_comb
    begin
        ctrl.cmp       = (state_reg == S_CMP);
        ctrl.act       = (state_reg == S_ACT) && rsp_free;
        ctrl.op        = op_reg;
        ctrl.any_match = |match_vec;
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] right_value;

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value = '0;
        end
        else
        begin : g_link
            assign right_value = cell_value[i+1];
        end

        ost_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .key         (key_reg),
            .left_valid  (left_valid[i]),
            .right_valid (right_valid[i]),
            .right_value (right_value),
            .right_mark  (right_mark[i]),
            .value       (cell_value[i]),
            .valid       (valid_vec[i]),
            .mark        (mark_vec[i]),
            .match       (match_vec[i])
        );
    end

    // element count from the packed occupancy edge
    always_comb
    begin
        count_enc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (valid_vec[i] && !right_valid[i])
            begin
                count_enc = count_enc | CW'(i + 1);
            end
        end
    end

    // sequencer and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_INSERT;
            key_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg    <= req_data.operation;
                        key_reg   <= VALUE_BITS'(req_data.value);
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_ACT;
                end
                S_ACT:
                begin
                    if (rsp_free)
                    begin
                        unique case (op_reg)
                            OP_INSERT:
                            begin
                                state_reg <= S_IDLE;
                                if (ctrl.any_match)
                                begin
                                    rsp_data_reg <= '{STATUS_MISS, count_t'(count_reg)};
                                end
                                else if (full)
                                begin
                                    rsp_data_reg <= '{STATUS_FULL, count_t'(count_reg)};
                                end
                                else
                                begin
                                    count_reg    <= count_reg + 1'b1;
                                    rsp_data_reg <= '{STATUS_OK, count_t'(count_reg + 1'b1)};
                                end
                            end
                            OP_REMOVE:
                            begin
                                state_reg <= S_PACK;
                                if (ctrl.any_match)
                                begin
                                    count_reg    <= count_reg - 1'b1;
                                    rsp_data_reg <= '{STATUS_OK, count_t'(count_reg - 1'b1)};
                                end
                                else
                                begin
                                    rsp_data_reg <= '{STATUS_MISS, count_t'(count_reg)};
                                end
                            end
                            OP_MARK:
                            begin
                                state_reg    <= S_IDLE;
                                rsp_data_reg <= '{(ctrl.any_match ? STATUS_OK : STATUS_MISS),
                                                  count_t'(count_reg)};
                            end
                            OP_FINISH:
                            begin
                                state_reg <= S_PACK;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PACK:
                begin
                    if (settled)
                    begin
                        if (op_reg == OP_FINISH)
                        begin
                            if (rsp_free)
                            begin
                                count_reg    <= count_enc;
                                rsp_data_reg <= '{STATUS_OK, count_t'(count_enc)};
                                state_reg    <= S_IDLE;
                            end
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // row is packed whenever a new request can be taken
    a_packed_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> settled)
        else $error("occupancy has a gap while idle");

    // tracked count agrees with the occupancy edge when idle
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> count_enc == count_reg)
        else $error("element count disagrees with occupied cells");

    // marks only sit on occupied cells
    a_mark_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (mark_vec & ~valid_vec) == '0)
        else $error("keep mark on an empty cell");

    // except keep-finish, a request loads its response at the apply step when the register is free
    a_rsp_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACT && rsp_free && op_reg != OP_FINISH) |=> rsp_valid_reg)
        else $error("no response after apply step");

endmodule

>>> tb/testbench.sv
// self-checking testbench for ordered_set_table: directed probe table, then random episodes
// of fills, unions, intersections, mixed runs and noise, checked against an in-bench set predictor
// depends on ost_pkg and ordered_set_table
module testbench;
    import ost_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int VALUE_WIDTH   = 32;
    localparam int TOTAL_ITEMS   = 1750;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TIMEOUT_UNITS = 3000000;

    // one directed probe: request, whether the response is typed in, and that response
    typedef struct packed {
        req_item_t req;
        logic      typed;
        rsp_item_t want;
    } probe_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req_data;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp_data;

    // predictor copy of the table
    logic signed [VALUE_WIDTH-1:0] table_vals [TABLE_DEPTH];
    bit                            table_marks [TABLE_DEPTH];
    int                            table_len;

    rsp_item_t expected_rsp [$];

    int items_sent;
    int directed_sent;
    int rsp_seen;
    int fail_count;
    int full_seen;
    int miss_seen;
    int finish_seen;
    int source_calm;
    int sink_calm;

    probe_row_t probe_rows [18] = '{
        '{'{OP_FINISH, 32'sh0000_0000}, 1'b1, '{STATUS_OK,   7'd0}},
        '{'{OP_REMOVE, 32'sh0000_0005}, 1'b1, '{STATUS_MISS, 7'd0}},
        '{'{OP_MARK,   32'sh0000_0005}, 1'b1, '{STATUS_MISS, 7'd0}},
        '{'{OP_INSERT, 32'sh8000_0000}, 1'b1, '{STATUS_OK,   7'd1}},
        '{'{OP_INSERT, 32'sh7fff_ffff}, 1'b1, '{STATUS_OK,   7'd2}},
        '{'{OP_INSERT, 32'sh0000_0000}, 1'b1, '{STATUS_OK,   7'd3}},
        '{'{OP_INSERT, 32'shffff_ffff}, 1'b1, '{STATUS_OK,   7'd4}},
        '{'{OP_INSERT, 32'sh7fff_ffff}, 1'b1, '{STATUS_MISS, 7'd4}},
        '{'{OP_MARK,   32'sh0000_0000}, 1'b0, '{STATUS_OK,   7'd0}},
        '{'{OP_MARK,   32'sh0000_0000}, 1'b0, '{STATUS_OK,   7'd0}},
        '{'{OP_MARK,   32'sh0000_3039}, 1'b1, '{STATUS_MISS, 7'd4}},
        '{'{OP_REMOVE, 32'sh8000_0000}, 1'b0, '{STATUS_OK,   7'd0}},
        '{'{OP_MARK,   32'shffff_ffff}, 1'b0, '{STATUS_OK,   7'd0}},
        '{'{OP_INSERT, 32'sh0000_004d}, 1'b0, '{STATUS_OK,   7'd0}},
        '{'{OP_FINISH, 32'shffff_ffff}, 1'b0, '{STATUS_OK,   7'd0}},
        '{'{OP_REMOVE, 32'sh0000_0000}, 1'b0, '{STATUS_OK,   7'd0}},
        '{'{OP_FINISH, 32'sh0000_0000}, 1'b1, '{STATUS_OK,   7'd0}},
        '{'{OP_REMOVE, 32'shffff_ffff}, 1'b1, '{STATUS_MISS, 7'd0}}
    };

    ordered_set_table #(
        .CAPACITY   (TABLE_DEPTH),
        .VALUE_BITS (VALUE_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("ordered_set_table verification failed");
        $finish;
    end

    // idle length: mostly none or short, a few long, with calm stretches of no idling
    function automatic int idle_length(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // element choice: held values, a small pool, the extremes, or any 32-bit value
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && table_len > 0)
            return table_vals[$urandom_range(0, table_len - 1)];
        if (r < 7)
            return $urandom_range(0, 15) - 8;
        if (r == 7)
            return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return $urandom();
    endfunction

    // set predictor: applies one request to the table copy and returns its response
    function automatic rsp_item_t apply_set_op(input req_item_t item);
        rsp_item_t rsp;
        int        slot;
        int        keep;
        int        i;
        rsp.status = STATUS_OK;
        slot = -1;
        for (i = 0; i < table_len; i++)
        begin
            if (table_vals[i] == item.value)
            begin
                slot = i;
                break;
            end
        end
        case (item.operation)
            OP_INSERT:
            begin
                if (slot >= 0)
                    rsp.status = STATUS_MISS;
                else if (table_len >= TABLE_DEPTH)
                    rsp.status = STATUS_FULL;
                else
                begin
                    table_vals[table_len]  = item.value;
                    table_marks[table_len] = 1'b0;
                    table_len++;
                end
            end
            OP_REMOVE:
            begin
                if (slot < 0)
                    rsp.status = STATUS_MISS;
                else
                begin
                    // close the gap, marks move with their entries
                    for (i = slot; i < table_len - 1; i++)
                    begin
                        table_vals[i]  = table_vals[i + 1];
                        table_marks[i] = table_marks[i + 1];
                    end
                    table_len--;
                    table_marks[table_len] = 1'b0;
                end
            end
            OP_MARK:
            begin
                if (slot < 0)
                    rsp.status = STATUS_MISS;
                else
                    table_marks[slot] = 1'b1;
            end
            default:
            begin
                // keep-finish packs marked entries in order and clears all marks
                keep = 0;
                for (i = 0; i < table_len; i++)
                begin
                    if (table_marks[i])
                    begin
                        table_vals[keep] = table_vals[i];
                        keep++;
                    end
                end
                table_len = keep;
                for (i = 0; i < TABLE_DEPTH; i++)
                    table_marks[i] = 1'b0;
                finish_seen++;
            end
        endcase
        if (rsp.status == STATUS_FULL)
            full_seen++;
        if (rsp.status == STATUS_MISS)
            miss_seen++;
        rsp.count = count_t'(table_len);
        return rsp;
    endfunction

    // offer one request transfer and record what it should answer
    task automatic send_op(input logic [1:0] op, input logic signed [31:0] value,
                           input bit typed, input rsp_item_t want);
        int        gap;
        bit        took;
        req_item_t item;
        rsp_item_t predicted;
        item.operation = op;
        item.value     = value;
        gap = idle_length(source_calm);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
        begin
            @(negedge clk);
            took = req_valid && req_ready;
            @(posedge clk);
        end
        while (!took);
        predicted = apply_set_op(item);
        expected_rsp.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // response side: random stalls, plus long hold-offs that back the block up
    initial
    begin
        int stall;
        int hold_mark;
        int holds_done;
        bit took;
        rsp_ready  = 1'b0;
        hold_mark  = 250;
        holds_done = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_done < 2 && rsp_seen >= hold_mark)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
                hold_mark += 700;
            end
            else
            begin
                stall = idle_length(sink_calm);
                if (stall > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = rsp_valid && rsp_ready;
                @(posedge clk);
            end
            while (!took);
        end
    end

    // response checker, sampled mid-cycle ahead of the transfer edge
    always @(negedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_seen++;
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected response: status %0d count %0d",
                       rsp_data.status, rsp_data.count);
                fail_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp_data.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                    fail_count++;
                end
                if (rsp_data.count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, rsp_data.count);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int         kind;
        int         n;
        int         k;
        bit         first_fill;
        logic [1:0] op;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        table_len   = 0;
        items_sent  = 0;
        rsp_seen    = 0;
        fail_count  = 0;
        full_seen   = 0;
        miss_seen   = 0;
        finish_seen = 0;
        source_calm = 0;
        sink_calm   = 0;
        first_fill  = 1'b1;
        for (k = 0; k < TABLE_DEPTH; k++)
            table_marks[k] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed probes
        foreach (probe_rows[i])
            send_op(probe_rows[i].req.operation, probe_rows[i].req.value,
                    probe_rows[i].typed, probe_rows[i].want);
        directed_sent = items_sent;

        // random episodes, the first one always fills the table
        while (items_sent < TOTAL_ITEMS)
        begin
            kind = first_fill ? 0 : $urandom_range(0, 99);
            first_fill = 1'b0;
            if (kind < 15)
            begin
                // fill to capacity, then new values and duplicates on a full table
                while (table_len < TABLE_DEPTH)
                    send_op(OP_INSERT, $urandom(), 1'b0, '0);
                n = $urandom_range(2, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 1))
                        send_op(OP_INSERT, $urandom(), 1'b0, '0);
                    else
                        send_op(OP_INSERT, pick_value(), 1'b0, '0);
                end
            end
            else if (kind < 40)
            begin
                // intersection: marks then keep-finish
                n = $urandom_range(0, table_len + 3);
                repeat (n)
                    send_op(OP_MARK, pick_value(), 1'b0, '0);
                send_op(OP_FINISH, $urandom(), 1'b0, '0);
            end
            else if (kind < 58)
            begin
                // union: a run of inserts
                n = $urandom_range(1, 12);
                repeat (n)
                    send_op(OP_INSERT, pick_value(), 1'b0, '0);
            end
            else if (kind < 85)
            begin
                // mixed operations on mostly held values
                n = $urandom_range(5, 20);
                repeat (n)
                begin
                    k = $urandom_range(0, 9);
                    if (k < 4)
                        op = OP_INSERT;
                    else if (k < 7)
                        op = OP_REMOVE;
                    else if (k < 9)
                        op = OP_MARK;
                    else
                        op = OP_FINISH;
                    send_op(op, pick_value(), 1'b0, '0);
                end
            end
            else
            begin
                // noise: any operation, any value
                n = $urandom_range(5, 15);
                repeat (n)
                    send_op(2'($urandom_range(0, 3)), $urandom(), 1'b0, '0);
            end
        end
        req_valid <= 1'b0;

        // drain, then allow for a trailing gap-closing pass
        for (k = 0; k < DRAIN_LIMIT && expected_rsp.size() != 0; k++)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (expected_rsp.size() != 0)
        begin
            $error("%0d responses never arrived", expected_rsp.size());
            fail_count++;
        end

        $display("%0d requests sent (%0d directed), %0d responses checked",
                 items_sent, directed_sent, rsp_seen);
        $display("full rejects %0d, duplicate or absent %0d, keep-finish passes %0d",
                 full_seen, miss_seen, finish_seen);
        if (fail_count == 0)
            $display("ordered_set_table verification clean");
        else
            $display("ordered_set_table verification failed");
        $finish;
    end

endmodule
